// ===== rtl/ucrh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucrh_pkg
// Shared types, codes and constants of the endpoint-0 standard request handler.
// ----------------------------------------------------------------------------
package ucrh_pkg;

  // Largest IN packet on endpoint 0, and the cap actually applied (field is 10 bits)
  localparam int unsigned MaxPacket = 512;
  localparam logic [9:0]  PktCap    = (MaxPacket > 1023) ? 10'd1023 : 10'(MaxPacket);

  // Event kinds
  localparam logic [1:0] KIND_SETUP  = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_XFER   = 2'd2;

  // Standard request codes (bRequest)
  localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE  = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE  = 8'd11;

  // bmRequestType fields
  localparam logic [7:0] RTYPE_TYPE_MASK  = 8'h60;
  localparam logic [7:0] RTYPE_RECIP_MASK = 8'h1F;
  localparam logic [7:0] RTYPE_RECIP_EP   = 8'h02;
  localparam int unsigned RtypeDirBit     = 7;

  // Descriptor types (wValue high byte)
  localparam logic [7:0] DTYPE_DEVICE = 8'd1;
  localparam logic [7:0] DTYPE_CONFIG = 8'd2;
  localparam logic [7:0] DTYPE_STRING = 8'd3;
  localparam logic [7:0] DTYPE_BOS    = 8'd15;
  localparam logic [7:0] MAX_STR_IDX  = 8'd3;

  // Endpoint numbers allowed for halt features
  localparam logic [6:0] EP_NUM_MASK = 7'h7F;
  localparam logic [6:0] EP_NUM_MAX  = 7'd15;

  // Descriptor source codes
  localparam logic [2:0] DESC_INLINE  = 3'd0;
  localparam logic [2:0] DESC_DEVICE  = 3'd1;
  localparam logic [2:0] DESC_CONFIG  = 3'd2;
  localparam logic [2:0] DESC_LANG    = 3'd3;
  localparam logic [2:0] DESC_BOS     = 3'd7;

  // Halt actions
  localparam logic [1:0] HALT_NONE  = 2'd0;
  localparam logic [1:0] HALT_SET   = 2'd1;
  localparam logic [1:0] HALT_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_DEVICE_LEN  = 3'd0;
  localparam logic [2:0] CFG_CONFIG_LEN  = 3'd1;
  localparam logic [2:0] CFG_LANG_LEN    = 3'd2;
  localparam logic [2:0] CFG_MAKER_LEN   = 3'd3;
  localparam logic [2:0] CFG_PRODUCT_LEN = 3'd4;
  localparam logic [2:0] CFG_SERIAL_LEN  = 3'd5;
  localparam logic [2:0] CFG_BOS_LEN     = 3'd6;
  localparam logic [2:0] CFG_CONFIG_NUM  = 3'd7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic [7:0]  device_desc_len;
    logic [15:0] config_desc_len;
    logic [7:0]  lang_desc_len;
    logic [7:0]  maker_desc_len;
    logic [7:0]  product_desc_len;
    logic [7:0]  serial_desc_len;
    logic [15:0] bos_desc_len;
    logic [7:0]  config_number;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
    logic [2:0]  endpoint_number;
    logic        endpoint_in;
  } req_t;

  typedef struct packed {
    logic        stall_res;
    logic        send_packet;
    logic [9:0]  packet_len;
    logic [2:0]  descriptor_choice;
    logic [15:0] descriptor_offset;
    logic [15:0] inline_reply;
    logic        out_ack;
    logic [1:0]  halt_action;
    logic [7:0]  halt_endpoint;
    logic        address_apply;
    logic [7:0]  device_address;
    logic        enumerated;
  } res_t;

  typedef struct packed {
    logic [15:0] remaining_len;
    logic [15:0] current_offset;
    logic [2:0]  current_descriptor;
    logic        address_pending;
    logic [7:0]  pending_address;
    logic [7:0]  active_config;
    logic        enum_flag;
  } ctl_state_t;

  // Clamp a byte count to one packet
  function automatic logic [9:0] cap_packet(input logic [15:0] n);
    cap_packet = (n > {6'd0, PktCap}) ? PktCap : n[9:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ucrh_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucrh_if
// Valid/ready channels for control events in and packet commands out.
// ----------------------------------------------------------------------------
interface ucrh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_index;
  logic [15:0] request_length;
  logic [2:0]  endpoint_number;
  logic        endpoint_in;

  modport source (output valid, kind, request_type, request_code, request_value,
                  request_index, request_length, endpoint_number, endpoint_in,
                  input ready);
  modport sink   (input valid, kind, request_type, request_code, request_value,
                  request_index, request_length, endpoint_number, endpoint_in,
                  output ready);
endinterface

interface ucrh_res_if;
  logic        valid;
  logic        ready;
  logic        stall_res;
  logic        send_packet;
  logic [9:0]  packet_len;
  logic [2:0]  descriptor_choice;
  logic [15:0] descriptor_offset;
  logic [15:0] inline_reply;
  logic        out_ack;
  logic [1:0]  halt_action;
  logic [7:0]  halt_endpoint;
  logic        address_apply;
  logic [7:0]  device_address;
  logic        enumerated;

  modport source (output valid, stall_res, send_packet, packet_len, descriptor_choice,
                  descriptor_offset, inline_reply, out_ack, halt_action, halt_endpoint,
                  address_apply, device_address, enumerated,
                  input ready);
  modport sink   (input valid, stall_res, send_packet, packet_len, descriptor_choice,
                  descriptor_offset, inline_reply, out_ack, halt_action, halt_endpoint,
                  address_apply, device_address, enumerated,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/usb_control_request_handler_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usb_control_request_handler_top
// Endpoint-0 standard request handler: one packet command per control event.
// ----------------------------------------------------------------------------
// Path: a taken event waits in the input register until the result register is
//   free or being drained, then its command is registered there and is valid.
// Throughput: one event per cycle while the result channel is not stalled; the
//   decode is a single pass of compare and subtract logic between the input register and the result register.
// Reset (rst_ni low, asynchronous): pipeline empty, all reply/address/config
//   state cleared, configuration registers back to their defaults.
// ----------------------------------------------------------------------------
module usb_control_request_handler_top
  import ucrh_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  ucrh_req_if.sink                 req_if,
  ucrh_res_if.source               res_if
);

  cfg_t       cfg;
  req_t       item_q;
  logic       item_vld_q;
  res_t       res_d, res_q;
  logic       res_vld_q;
  ctl_state_t st_q, st_d;
  logic       advance;
  logic       take;

  // Register block
  ucrh_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The held event moves on when the result register is free or being drained
  assign advance     = item_vld_q && (!res_vld_q || res_if.ready);
  assign req_if.ready = !item_vld_q || advance;
  assign take        = req_if.valid && req_if.ready;

  // Input register: valid bit under reset, payload free-running on acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (req_if.ready) begin
      item_vld_q <= req_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.kind            <= req_if.kind;
      item_q.request_type    <= req_if.request_type;
      item_q.request_code    <= req_if.request_code;
      item_q.request_value   <= req_if.request_value;
      item_q.request_index   <= req_if.request_index;
      item_q.request_length  <= req_if.request_length;
      item_q.endpoint_number <= req_if.endpoint_number;
      item_q.endpoint_in     <= req_if.endpoint_in;
    end
  end

  // Decode against current state; state commits with the result
  ucrh_decode u_dec (
    .item_i (item_q),
    .cfg_i  (cfg),
    .st_i   (st_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        st_q      <= st_d;
        res_vld_q <= 1'b1;
      end else if (res_if.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_if.valid             = res_vld_q;
  assign res_if.stall_res         = res_q.stall_res;
  assign res_if.send_packet       = res_q.send_packet;
  assign res_if.packet_len        = res_q.packet_len;
  assign res_if.descriptor_choice = res_q.descriptor_choice;
  assign res_if.descriptor_offset = res_q.descriptor_offset;
  assign res_if.inline_reply      = res_q.inline_reply;
  assign res_if.out_ack           = res_q.out_ack;
  assign res_if.halt_action       = res_q.halt_action;
  assign res_if.halt_endpoint     = res_q.halt_endpoint;
  assign res_if.address_apply     = res_q.address_apply;
  assign res_if.device_address    = res_q.device_address;
  assign res_if.enumerated        = res_q.enumerated;

endmodule
`default_nettype wire

// ===== rtl/ucrh_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucrh_cfg_regs
// Descriptor length and configuration number registers, write-only port.
// ----------------------------------------------------------------------------
module ucrh_cfg_regs
  import ucrh_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEVICE_LEN:  cfg_d.device_desc_len  = cfg_wdata_i[7:0];
        CFG_CONFIG_LEN:  cfg_d.config_desc_len  = cfg_wdata_i;
        CFG_LANG_LEN:    cfg_d.lang_desc_len    = cfg_wdata_i[7:0];
        CFG_MAKER_LEN:   cfg_d.maker_desc_len   = cfg_wdata_i[7:0];
        CFG_PRODUCT_LEN: cfg_d.product_desc_len = cfg_wdata_i[7:0];
        CFG_SERIAL_LEN:  cfg_d.serial_desc_len  = cfg_wdata_i[7:0];
        CFG_BOS_LEN:     cfg_d.bos_desc_len     = cfg_wdata_i;
        CFG_CONFIG_NUM:  cfg_d.config_number    = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_desc_len  <= 8'd18;
      cfg_q.config_desc_len  <= 16'd0;
      cfg_q.lang_desc_len    <= 8'd4;
      cfg_q.maker_desc_len   <= 8'd0;
      cfg_q.product_desc_len <= 8'd0;
      cfg_q.serial_desc_len  <= 8'd0;
      cfg_q.bos_desc_len     <= 16'd0;
      cfg_q.config_number    <= 8'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/ucrh_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucrh_decode
// Single-pass request decode: packet command and next control state per event.
// ----------------------------------------------------------------------------
module ucrh_decode
  import ucrh_pkg::*;
(
  input  wire req_t       item_i,
  input  wire cfg_t       cfg_i,
  input  wire ctl_state_t st_i,
  output ctl_state_t      st_o,
  output res_t            res_o
);

  logic        stall;
  logic [15:0] total;
  logic [15:0] dl;
  logic [2:0]  desc;
  logic [15:0] inl;
  logic [1:0]  halt;
  logic [7:0]  hep;
  logic [7:0]  dtype;
  logic [7:0]  sidx;
  logic [7:0]  v8;
  logic [6:0]  epn;
  logic [9:0]  first;
  logic [9:0]  nxt;

  always_comb begin
    st_o  = st_i;
    res_o = '0;
    stall = 1'b0;
    total = item_i.request_length;
    dl    = '0;
    desc  = DESC_INLINE;
    inl   = '0;
    halt  = HALT_NONE;
    hep   = '0;
    dtype = item_i.request_value[15:8];
    sidx  = item_i.request_value[7:0];
    v8    = item_i.request_value[7:0];
    epn   = item_i.request_index[6:0] & EP_NUM_MASK;
    first = '0;
    nxt   = cap_packet(st_i.remaining_len);

    unique case (item_i.kind)
      KIND_SETUP: begin
        st_o.address_pending = 1'b0;
        if ((item_i.request_type & RTYPE_TYPE_MASK) != 8'd0) begin
          stall = 1'b1;
        end else begin
          unique case (item_i.request_code) inside
            REQ_GET_DESCRIPTOR: begin
              if (dtype == DTYPE_DEVICE) begin
                desc = DESC_DEVICE;
                dl   = {8'd0, cfg_i.device_desc_len};
              end else if (dtype == DTYPE_CONFIG) begin
                desc = DESC_CONFIG;
                dl   = cfg_i.config_desc_len;
              end else if (dtype == DTYPE_STRING && sidx <= MAX_STR_IDX) begin
                desc = DESC_LANG + sidx[2:0];
                case (sidx[1:0])
                  2'd0:    dl = {8'd0, cfg_i.lang_desc_len};
                  2'd1:    dl = {8'd0, cfg_i.maker_desc_len};
                  2'd2:    dl = {8'd0, cfg_i.product_desc_len};
                  default: dl = {8'd0, cfg_i.serial_desc_len};
                endcase
              end else if (dtype == DTYPE_BOS) begin
                desc = DESC_BOS;
                dl   = cfg_i.bos_desc_len;
              end else begin
                stall = 1'b1;
              end
              total = (item_i.request_length < dl) ? item_i.request_length : dl;
            end
            REQ_SET_ADDRESS: begin
              st_o.address_pending = 1'b1;
              st_o.pending_address = v8;
            end
            REQ_GET_CONFIG: begin
              inl   = {8'd0, st_i.active_config};
              total = {15'd0, item_i.request_length != 16'd0};
            end
            REQ_SET_CONFIG: begin
              if (v8 != 8'd0 && v8 != cfg_i.config_number) begin
                st_o.active_config = cfg_i.config_number;
                stall = 1'b1;
              end else begin
                st_o.active_config = v8;
                st_o.enum_flag     = (v8 != 8'd0);
              end
            end
            REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
              if ((item_i.request_type & RTYPE_RECIP_MASK) == RTYPE_RECIP_EP) begin
                // endpoint halt only; endpoint 0 and other selectors are no-ops
                if (v8 == 8'd0 && epn != 7'd0 && epn <= EP_NUM_MAX) begin
                  halt = (item_i.request_code == REQ_SET_FEATURE) ? HALT_SET : HALT_CLEAR;
                  hep  = item_i.request_index[7:0];
                end
              end else begin
                stall = 1'b1;
              end
            end
            REQ_GET_INTERFACE: total = {15'd0, item_i.request_length != 16'd0};
            REQ_SET_INTERFACE: ;
            REQ_GET_STATUS: begin
              total = (item_i.request_length < 16'd2) ? item_i.request_length : 16'd2;
            end
            default: stall = 1'b1;
          endcase
        end

        first = cap_packet(total);
        if (stall) begin
          st_o.remaining_len      = '0;
          st_o.current_offset     = '0;
          st_o.current_descriptor = DESC_INLINE;
          res_o.stall_res         = 1'b1;
        end else begin
          res_o.halt_action   = halt;
          res_o.halt_endpoint = hep;
          res_o.send_packet   = 1'b1;
          if (item_i.request_type[RtypeDirBit]) begin
            res_o.packet_len        = first;
            res_o.descriptor_choice = desc;
            res_o.inline_reply      = inl;
            st_o.remaining_len      = total - {6'd0, first};
            st_o.current_offset     = {6'd0, first};
            st_o.current_descriptor = desc;
          end else begin
            // host-to-device: zero-length status packet
            res_o.out_ack           = 1'b1;
            st_o.remaining_len      = '0;
            st_o.current_offset     = '0;
            st_o.current_descriptor = DESC_INLINE;
          end
        end
      end
      KIND_STATUS: begin
        if (st_i.address_pending) begin
          res_o.address_apply  = 1'b1;
          res_o.device_address = st_i.pending_address;
          st_o.address_pending = 1'b0;
        end
      end
      KIND_XFER: begin
        if (item_i.endpoint_number == 3'd0) begin
          if (item_i.endpoint_in) begin
            if (st_i.remaining_len != 16'd0) begin
              res_o.send_packet       = 1'b1;
              res_o.packet_len        = nxt;
              res_o.descriptor_choice = st_i.current_descriptor;
              res_o.descriptor_offset = st_i.current_offset;
              st_o.remaining_len      = st_i.remaining_len - {6'd0, nxt};
              st_o.current_offset     = st_i.current_offset + {6'd0, nxt};
            end
          end else begin
            res_o.out_ack = 1'b1;
          end
        end
      end
      default: ;
    endcase

    res_o.enumerated = st_o.enum_flag;
  end

endmodule
`default_nettype wire

// ===== tb/usb_control_request_handler_top_test.sv =====
// ----------------------------------------------------------------------------
// usb_control_request_handler_top_test
// Self-checking bench for the endpoint-0 request handler. Control events are
// driven over the request channel and every packet command is checked against
// an in-bench predictor of the handler's reply, address and config state.
// Directed cases come first, then random control transfers over several
// register settings and idling mixes, including a long output hold-off.
// ----------------------------------------------------------------------------
module usb_control_request_handler_top_test;
  import ucrh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Event kind that the handler does not act on (it still returns a command)
  localparam logic [1:0] KIND_NONE = 2'd3;

  // bmRequestType values used by the stimulus
  localparam logic [7:0] RT_DEV_OUT    = 8'h00;
  localparam logic [7:0] RT_IF_OUT     = 8'h01;
  localparam logic [7:0] RT_EP_OUT     = 8'h02;
  localparam logic [7:0] RT_VENDOR_OUT = 8'h40;
  localparam logic [7:0] RT_DEV_IN     = 8'h80;
  localparam logic [7:0] RT_IF_IN      = 8'h81;
  localparam logic [7:0] RT_DIR_IN     = 8'h80;

  // Requests and selectors not named in the package
  localparam logic [7:0] REQ_SET_DESCRIPTOR = 8'd7;   // standard but unsupported
  localparam logic [7:0] DTYPE_INTERFACE    = 8'd4;   // not served on its own
  localparam logic [7:0] FEAT_EP_HALT       = 8'd0;
  localparam logic [7:0] FEAT_REMOTE_WAKE   = 8'd1;
  localparam logic [2:0] EP_CONTROL         = 3'd0;

  localparam int unsigned LatencyCycles = 2;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned PhaseItems    = 145;

  // --------------------------------------------------------------------------
  // Predictor of the handler plus the store of commands still owed by the DUT
  // --------------------------------------------------------------------------
  class ep0_command_predictor;
    cfg_t        regs;
    ctl_state_t  st;
    res_t        expected_cmds[$];
    int unsigned faults;

    function new();
      regs                  = '0;
      regs.device_desc_len  = 8'd18;
      regs.lang_desc_len    = 8'd4;
      regs.config_number    = 8'd1;
      st                    = '0;
      faults                = 0;
    endfunction

    function logic [9:0] packet_bytes(logic [15:0] n);
      return (n > {6'd0, PktCap}) ? PktCap : n[9:0];
    endfunction

    // One accepted event: advance the state and queue the command it owes
    function void take_event(req_t q);
      res_t        r;
      logic        stall;
      logic [15:0] total, dl;
      logic [2:0]  desc;
      logic [7:0]  cfg_byte, ep;
      logic [1:0]  halt;
      logic [9:0]  n;
      r        = '0;
      stall    = 1'b0;
      total    = q.request_length;
      dl       = '0;
      desc     = DESC_INLINE;
      cfg_byte = '0;
      ep       = '0;
      halt     = HALT_NONE;
      case (q.kind)
        KIND_SETUP: begin
          st.address_pending = 1'b0;
          if ((q.request_type & RTYPE_TYPE_MASK) != 8'h00) begin
            stall = 1'b1;
          end else begin
            case (q.request_code)
              REQ_GET_DESCRIPTOR: begin
                case (q.request_value[15:8])
                  DTYPE_DEVICE: begin
                    desc = DESC_DEVICE;
                    dl   = {8'h00, regs.device_desc_len};
                  end
                  DTYPE_CONFIG: begin
                    desc = DESC_CONFIG;
                    dl   = regs.config_desc_len;
                  end
                  DTYPE_STRING: begin
                    if (q.request_value[7:0] > MAX_STR_IDX) begin
                      stall = 1'b1;
                    end else begin
                      desc = DESC_LANG + q.request_value[2:0];
                      case (q.request_value[1:0])
                        2'd0:    dl = {8'h00, regs.lang_desc_len};
                        2'd1:    dl = {8'h00, regs.maker_desc_len};
                        2'd2:    dl = {8'h00, regs.product_desc_len};
                        default: dl = {8'h00, regs.serial_desc_len};
                      endcase
                    end
                  end
                  DTYPE_BOS: begin
                    desc = DESC_BOS;
                    dl   = regs.bos_desc_len;
                  end
                  default: stall = 1'b1;
                endcase
                if (dl < total) total = dl;
              end
              REQ_SET_ADDRESS: begin
                st.address_pending = 1'b1;
                st.pending_address = q.request_value[7:0];
              end
              REQ_GET_CONFIG: begin
                cfg_byte = st.active_config;
                if (total > 16'd1) total = 16'd1;
              end
              REQ_SET_CONFIG: begin
                if (q.request_value[7:0] != 8'h00 &&
                    q.request_value[7:0] != regs.config_number) begin
                  st.active_config = regs.config_number;
                  stall            = 1'b1;
                end else begin
                  st.active_config = q.request_value[7:0];
                  st.enum_flag     = (q.request_value[7:0] != 8'h00);
                end
              end
              REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                if ((q.request_type & RTYPE_RECIP_MASK) != RTYPE_RECIP_EP) begin
                  stall = 1'b1;
                end else begin
                  ep = q.request_index[7:0];
                  // only a halt on endpoints 1..15 does anything
                  if (q.request_value[7:0] == FEAT_EP_HALT &&
                      (ep[6:0] & EP_NUM_MASK) != 7'd0 &&
                      (ep[6:0] & EP_NUM_MASK) <= EP_NUM_MAX) begin
                    halt = (q.request_code == REQ_SET_FEATURE) ? HALT_SET : HALT_CLEAR;
                  end
                end
              end
              REQ_GET_INTERFACE: if (total > 16'd1) total = 16'd1;
              REQ_SET_INTERFACE: ;
              REQ_GET_STATUS:    if (total > 16'd2) total = 16'd2;
              default:           stall = 1'b1;
            endcase
          end
          if (stall) begin
            st.remaining_len      = '0;
            st.current_offset     = '0;
            st.current_descriptor = DESC_INLINE;
            r.stall_res           = 1'b1;
          end else begin
            r.send_packet   = 1'b1;
            r.halt_action   = halt;
            r.halt_endpoint = (halt != HALT_NONE) ? ep : 8'h00;
            if (q.request_type[RtypeDirBit]) begin
              n                     = packet_bytes(total);
              r.packet_len          = n;
              r.descriptor_choice   = desc;
              r.inline_reply        = {8'h00, cfg_byte};
              st.remaining_len      = total - {6'd0, n};
              st.current_offset     = {6'd0, n};
              st.current_descriptor = desc;
            end else begin
              r.out_ack             = 1'b1;
              st.remaining_len      = '0;
              st.current_offset     = '0;
              st.current_descriptor = DESC_INLINE;
            end
          end
        end
        KIND_STATUS: begin
          if (st.address_pending) begin
            r.address_apply    = 1'b1;
            r.device_address   = st.pending_address;
            st.address_pending = 1'b0;
          end
        end
        KIND_XFER: begin
          if (q.endpoint_number == EP_CONTROL) begin
            if (!q.endpoint_in) begin
              r.out_ack = 1'b1;
            end else if (st.remaining_len != 16'd0) begin
              n                   = packet_bytes(st.remaining_len);
              r.send_packet       = 1'b1;
              r.packet_len        = n;
              r.descriptor_choice = st.current_descriptor;
              r.descriptor_offset = st.current_offset;
              st.remaining_len    = st.remaining_len - {6'd0, n};
              st.current_offset   = st.current_offset + {6'd0, n};
            end
          end
        end
        default: ;
      endcase
      r.enumerated = st.enum_flag;
      expected_cmds.push_back(r);
    endfunction

    // One accepted command: compare with the oldest one owed
    function void check_command(res_t got);
      res_t  want;
      string diff;
      if (expected_cmds.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected command %p", got);
        return;
      end
      want = expected_cmds.pop_front();
      diff = "";
      if (got.stall_res != want.stall_res)                 diff = {diff, " stall_res"};
      if (got.send_packet != want.send_packet)             diff = {diff, " send_packet"};
      if (got.packet_len != want.packet_len)               diff = {diff, " packet_len"};
      if (got.descriptor_choice != want.descriptor_choice) diff = {diff, " descriptor_choice"};
      if (got.descriptor_offset != want.descriptor_offset) diff = {diff, " descriptor_offset"};
      if (got.inline_reply != want.inline_reply)           diff = {diff, " inline_reply"};
      if (got.out_ack != want.out_ack)                     diff = {diff, " out_ack"};
      if (got.halt_action != want.halt_action)             diff = {diff, " halt_action"};
      if (got.halt_endpoint != want.halt_endpoint)         diff = {diff, " halt_endpoint"};
      if (got.address_apply != want.address_apply)         diff = {diff, " address_apply"};
      if (got.device_address != want.device_address)       diff = {diff, " device_address"};
      if (got.enumerated != want.enumerated)               diff = {diff, " enumerated"};
      if (diff != "") begin
        faults++;
        if (faults <= 10) begin
          $display("command mismatch in%s", diff);
          $display("  expected %p", want);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  ucrh_req_if req_if ();
  ucrh_res_if res_if ();

  ep0_command_predictor cmd_model;

  int unsigned send_idle_pct;    // chance per item that the sender idles first
  int unsigned recv_stall_pct;   // chance per cycle that the receiver stalls
  int unsigned hold_requests;    // bumped to ask for one long output hold-off
  int unsigned items_sent;
  int unsigned cycle_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  usb_control_request_handler_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_if      (req_if),
    .res_if      (res_if)
  );

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Both channels are sampled at the edge, before any of this edge's updates
  // land. Commands are checked before the new event is noted, so a command
  // arriving with nothing owed can never be matched against a fresh event.
  always @(posedge clk_i) begin
    res_t got;
    req_t taken;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = {res_if.stall_res, res_if.send_packet, res_if.packet_len,
               res_if.descriptor_choice, res_if.descriptor_offset, res_if.inline_reply,
               res_if.out_ack, res_if.halt_action, res_if.halt_endpoint,
               res_if.address_apply, res_if.device_address, res_if.enumerated};
        cmd_model.check_command(got);
      end
      if (req_if.valid && req_if.ready) begin
        taken = {req_if.kind, req_if.request_type, req_if.request_code,
                 req_if.request_value, req_if.request_index, req_if.request_length,
                 req_if.endpoint_number, req_if.endpoint_in};
        cmd_model.take_event(taken);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off each time one is requested.
  // The hold-off is counted here so the sender carries on regardless.
  initial begin
    int unsigned hold_left, hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one event and return at the edge its transaction completes. Valid is
  // left high so a back-to-back event needs no second assignment that step.
  task automatic send_event(input req_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.kind            <= q.kind;
    req_if.request_type    <= q.request_type;
    req_if.request_code    <= q.request_code;
    req_if.request_value   <= q.request_value;
    req_if.request_index   <= q.request_index;
    req_if.request_length  <= q.request_length;
    req_if.endpoint_number <= q.endpoint_number;
    req_if.endpoint_in     <= q.endpoint_in;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  task automatic setup(input logic [7:0] rt, input logic [7:0] code,
                       input logic [15:0] val, input logic [15:0] idx,
                       input logic [15:0] len);
    req_t q;
    q                = '0;
    q.kind           = KIND_SETUP;
    q.request_type   = rt;
    q.request_code   = code;
    q.request_value  = val;
    q.request_index  = idx;
    q.request_length = len;
    send_event(q);
  endtask

  task automatic xfer_done(input logic [2:0] ep, input logic dir_in);
    req_t q;
    q                 = '0;
    q.kind            = KIND_XFER;
    q.endpoint_number = ep;
    q.endpoint_in     = dir_in;
    send_event(q);
  endtask

  task automatic status_done();
    req_t q;
    q      = '0;
    q.kind = KIND_STATUS;
    send_event(q);
  endtask

  // Stop offering and wait until every owed command has been taken, then
  // give the pipeline its latency to settle
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (cmd_model.expected_cmds.size() != 0);
    repeat (LatencyCycles + 2) @(posedge clk_i);
  endtask

  // Write all eight registers, one per cycle; the 8-bit ones get junk on top
  task automatic write_regs(input cfg_t c);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i  <= 1'b1;
      cfg_idx_i <= CfgIdxW'(i);
      case (CfgIdxW'(i))
        CFG_DEVICE_LEN:  cfg_wdata_i <= {8'($urandom), c.device_desc_len};
        CFG_CONFIG_LEN:  cfg_wdata_i <= c.config_desc_len;
        CFG_LANG_LEN:    cfg_wdata_i <= {8'($urandom), c.lang_desc_len};
        CFG_MAKER_LEN:   cfg_wdata_i <= {8'($urandom), c.maker_desc_len};
        CFG_PRODUCT_LEN: cfg_wdata_i <= {8'($urandom), c.product_desc_len};
        CFG_SERIAL_LEN:  cfg_wdata_i <= {8'($urandom), c.serial_desc_len};
        CFG_BOS_LEN:     cfg_wdata_i <= c.bos_desc_len;
        default:         cfg_wdata_i <= {8'($urandom), c.config_number};
      endcase
      @(posedge clk_i);
    end
    cfg_we_i      <= 1'b0;
    cmd_model.regs = c;
  endtask

  function automatic cfg_t random_regs();
    cfg_t c;
    c.device_desc_len  = 8'($urandom);
    c.config_desc_len  = 16'($urandom_range(0, 2000));
    c.lang_desc_len    = 8'($urandom);
    c.maker_desc_len   = 8'($urandom);
    c.product_desc_len = 8'($urandom);
    c.serial_desc_len  = 8'($urandom);
    c.bos_desc_len     = 16'($urandom_range(0, 1200));
    c.config_number    = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd1;
    return c;
  endfunction

  // One control transfer the way a host runs it: setup, data stage packets,
  // then the status stage. Some setups are deliberately malformed.
  task automatic random_transfer();
    logic [7:0]  rt, code, dtype;
    logic [15:0] val, idx, len, dl;
    int unsigned pick, packets;
    pick = $urandom_range(0, 99);
    if (pick < 70)      len = 16'($urandom_range(0, 70));
    else if (pick < 90) len = 16'($urandom_range(0, 1500));
    else if (pick < 95) len = 16'hFFFF;
    else                len = 16'($urandom);
    val = '0;
    idx = 16'($urandom_range(0, 3));
    case ($urandom_range(0, 11))
      0: begin
        rt   = RT_DIR_IN | 8'($urandom_range(0, 2));
        code = REQ_GET_STATUS;
      end
      1, 2: begin
        rt   = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 3)) : RT_EP_OUT;
        code = $urandom_range(0, 1) ? REQ_SET_FEATURE : REQ_CLEAR_FEATURE;
        val  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : {8'($urandom), FEAT_EP_HALT};
        idx  = {8'($urandom), $urandom_range(0, 1) ? RT_DIR_IN : 8'h00};
        idx[6:0] = ($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'($urandom_range(0, 17));
        len  = '0;
      end
      3: begin
        rt   = RT_DEV_OUT;
        code = REQ_SET_ADDRESS;
        val  = 16'($urandom);
        len  = '0;
      end
      4, 5: begin
        rt   = RT_DEV_IN;
        code = REQ_GET_DESCRIPTOR;
        case ($urandom_range(0, 5))
          0:       dtype = DTYPE_DEVICE;
          1, 2:    dtype = DTYPE_CONFIG;
          3:       dtype = DTYPE_STRING;
          4:       dtype = DTYPE_BOS;
          default: dtype = 8'($urandom);
        endcase
        val = {dtype, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4))};
      end
      6: begin
        rt   = RT_DEV_IN;
        code = REQ_GET_CONFIG;
        len  = 16'($urandom_range(0, 3));
      end
      7: begin
        rt   = RT_DEV_OUT;
        code = REQ_SET_CONFIG;
        case ($urandom_range(0, 2))
          0:       val = {8'($urandom), 8'h00};
          1:       val = {8'($urandom), cmd_model.regs.config_number};
          default: val = 16'($urandom);
        endcase
        len = '0;
      end
      8: begin
        rt   = RT_IF_IN;
        code = REQ_GET_INTERFACE;
      end
      9: begin
        rt   = RT_IF_OUT;
        code = REQ_SET_INTERFACE;
        val  = 16'($urandom_range(0, 3));
        len  = '0;
      end
      10: begin
        // class, vendor or reserved types and anything else the host might try
        rt   = 8'($urandom);
        code = 8'($urandom_range(0, 15));
        val  = 16'($urandom);
        idx  = 16'($urandom);
      end
      default: begin
        rt   = 8'($urandom) & ~RTYPE_TYPE_MASK;
        code = 8'($urandom);
        val  = 16'($urandom);
      end
    endcase
    // now and then the direction bit disagrees with the request
    if ($urandom_range(0, 9) == 0) rt = rt ^ RT_DIR_IN;
    setup(rt, code, val, idx, len);

    if (rt[RtypeDirBit]) begin
      // only the long descriptors can need more than one packet
      dl = 16'd255;
      if (code == REQ_GET_DESCRIPTOR && val[15:8] == DTYPE_CONFIG)
        dl = cmd_model.regs.config_desc_len;
      if (code == REQ_GET_DESCRIPTOR && val[15:8] == DTYPE_BOS)
        dl = cmd_model.regs.bos_desc_len;
      if (len < dl) dl = len;
      packets = int'(dl) / int'(PktCap) + 1;
      repeat (packets) xfer_done(EP_CONTROL, 1'b1);
      xfer_done(EP_CONTROL, 1'b0);
    end else begin
      xfer_done(EP_CONTROL, 1'b1);
    end
    status_done();
  endtask

  task automatic random_noise();
    req_t q;
    q = req_t'({$urandom, $urandom, $urandom});
    if ($urandom_range(0, 1)) q.kind = $urandom_range(0, 1) ? KIND_XFER : KIND_NONE;
    send_event(q);
  endtask

  task automatic run_random(input int unsigned upto);
    while (items_sent < upto) begin
      if ($urandom_range(0, 99) < 15) random_noise();
      else                            random_transfer();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t c;
    cmd_model              = new();
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    hold_requests          = 0;
    items_sent             = 0;
    cycle_count            = 0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = '0;
    cfg_wdata_i            = '0;
    req_if.valid           = 1'b0;
    req_if.kind            = KIND_SETUP;
    req_if.request_type    = '0;
    req_if.request_code    = '0;
    req_if.request_value   = '0;
    req_if.request_index   = '0;
    req_if.request_length  = '0;
    req_if.endpoint_number = '0;
    req_if.endpoint_in     = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // ---- Directed, on the register defaults ----
    setup(RT_DEV_IN, REQ_GET_DESCRIPTOR, {DTYPE_DEVICE, 8'd0}, 16'd0, 16'd64);
    setup(RT_DEV_IN, REQ_GET_DESCRIPTOR, {DTYPE_STRING, 8'd0}, 16'h0409, 16'hFFFF);
    // string index past the serial number, and a type served nowhere: stall
    setup(RT_DEV_IN, REQ_GET_DESCRIPTOR, {DTYPE_STRING, 8'd4}, 16'h0409, 16'd255);
    setup(RT_DEV_IN, REQ_GET_DESCRIPTOR, {DTYPE_INTERFACE, 8'd0}, 16'd0, 16'd9);
    // address only lands on the following status stage
    setup(RT_DEV_OUT, REQ_SET_ADDRESS, 16'hAB7F, 16'd0, 16'd0);
    status_done();
    // a fresh setup in between drops the pending address
    setup(RT_DEV_OUT, REQ_SET_ADDRESS, 16'h0011, 16'd0, 16'd0);
    setup(RT_DEV_IN, REQ_GET_STATUS, 16'd0, 16'd0, 16'hFFFF);
    status_done();
    // configuration: good value, readback, wrong value, back to unconfigured
    setup(RT_DEV_OUT, REQ_SET_CONFIG, 16'h0001, 16'd0, 16'd0);
    setup(RT_DEV_IN, REQ_GET_CONFIG, 16'd0, 16'd0, 16'hFFFF);
    setup(RT_DEV_OUT, REQ_SET_CONFIG, 16'h0002, 16'd0, 16'd0);
    setup(RT_DEV_OUT, REQ_SET_CONFIG, 16'hFF00, 16'd0, 16'd0);
    // endpoint halt: set, clear, endpoint zero, endpoint 16, other selector,
    // wrong recipient
    setup(RT_EP_OUT, REQ_SET_FEATURE, {8'd0, FEAT_EP_HALT}, 16'hFF81, 16'd0);
    setup(RT_EP_OUT, REQ_CLEAR_FEATURE, {8'd0, FEAT_EP_HALT}, 16'h000F, 16'd0);
    setup(RT_EP_OUT, REQ_SET_FEATURE, {8'd0, FEAT_EP_HALT}, 16'h0080, 16'd0);
    setup(RT_EP_OUT, REQ_SET_FEATURE, {8'd0, FEAT_EP_HALT}, 16'h0090, 16'd0);
    setup(RT_EP_OUT, REQ_SET_FEATURE, {8'd0, FEAT_REMOTE_WAKE}, 16'h0001, 16'd0);
    setup(RT_DEV_OUT, REQ_SET_FEATURE, {8'd0, FEAT_EP_HALT}, 16'h0001, 16'd0);
    // non-standard type, unsupported request, interface requests, OUT-direction
    setup(RT_VENDOR_OUT, REQ_GET_STATUS, 16'd0, 16'd0, 16'd0);
    setup(RT_DEV_IN, REQ_SET_DESCRIPTOR, 16'd0, 16'd0, 16'd8);
    setup(RT_IF_IN, REQ_GET_INTERFACE, 16'd0, 16'd0, 16'd0);
    setup(RT_IF_OUT, REQ_SET_INTERFACE, 16'd1, 16'd0, 16'd0);
    setup(RT_DEV_OUT, REQ_GET_DESCRIPTOR, {DTYPE_DEVICE, 8'd0}, 16'd0, 16'd18);
    xfer_done(EP_CONTROL, 1'b0);
    xfer_done(3'd5, 1'b1);
    drain();

    // ---- Directed packet splitting on a long configuration set ----
    c                 = random_regs();
    c.config_desc_len = 16'd1300;
    c.bos_desc_len    = 16'hFFFF;
    write_regs(c);
    setup(RT_DEV_IN, REQ_GET_DESCRIPTOR, {DTYPE_CONFIG, 8'd0}, 16'd0, 16'hFFFF);
    repeat (3) xfer_done(EP_CONTROL, 1'b1);   // 512, 276, then nothing left
    status_done();

    // ---- Random phases: each with its own registers and idling mix ----
    drain();
    write_regs(random_regs());
    run_random(items_sent + PhaseItems);

    drain();
    write_regs('0);                            // every length zero, config 0
    send_idle_pct = 58;
    run_random(items_sent + PhaseItems);

    drain();
    write_regs('1);                            // every register at its top
    send_idle_pct  = 0;
    recv_stall_pct = 58;
    run_random(items_sent + PhaseItems);

    drain();
    write_regs(random_regs());
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    run_random(items_sent + PhaseItems);

    // Back-pressure: the receiver holds off while the sender keeps going, so
    // the pipeline fills and the request side stalls
    drain();
    write_regs(random_regs());
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    run_random(items_sent + PhaseItems);

    drain();
    if (cmd_model.faults == 0 && cmd_model.expected_cmds.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
